@@ rtl/core/potmr_pkg.sv @@
`timescale 1ns / 1ps
package potmr_pkg;

  localparam int MAX_JOBS = 16;
  localparam int SLOT_W   = $clog2(MAX_JOBS);

  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;
  localparam logic [1:0] OP_TICK     = 2'd3;

  localparam logic [1:0] KIND_SCHEDULE = 2'd0;
  localparam logic [1:0] KIND_CANCEL   = 2'd1;
  localparam logic [1:0] KIND_QUERY    = 2'd2;
  localparam logic [1:0] KIND_FIRED    = 2'd3;

endpackage

@@ rtl/core/periodic_oneshot_timer_table.sv @@
// Schedule: its reply word is on the outputs in the cycle after start.
// Cancel and query: one scan of the slot memory, then a single reply word from the end state.
// Tick: one scan of the slot memory per fired job plus a final scan that finds no due job.
// Throughput is one word per cycle at most; the receiver cannot stall the result port.
// Synchronous reset clears the clock and all slot valid bits at once and sets the id counter to 1.
`timescale 1ns / 1ps
module periodic_oneshot_timer_table
  import potmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] delay_ms,
  input  logic [31:0] period_ms,
  input  logic [31:0] job_id,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [31:0] result_id,
  output logic        ok,
  output logic        last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_END
  } state_t;

  state_t state;

  logic [63:0] now_ms;
  logic [31:0] next_job_id;
  logic [MAX_JOBS-1:0] slot_valid;
  logic [MAX_JOBS-1:0] fired;

  logic [31:0] id_mem  [MAX_JOBS];
  logic [63:0] dl_mem  [MAX_JOBS];
  logic [31:0] per_mem [MAX_JOBS];
  logic [31:0] id_q;
  logic [63:0] dl_q;
  logic [31:0] per_q;

  logic [1:0]  op_r;
  logic [31:0] op_id;

  logic [SLOT_W-1:0] scan_idx;
  logic [SLOT_W-1:0] chk_idx;
  logic              chk_vld;

  logic              found;
  logic [SLOT_W-1:0] match_idx;

  logic              best_vld;
  logic [SLOT_W-1:0] best_idx;
  logic [63:0]       best_dl;
  logic [31:0]       best_per;
  logic [31:0]       best_id;

  logic        pend_vld;
  logic [31:0] pend_id;

  logic              accept;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              sched_we;
  logic              dl_we;
  logic [63:0]       dl_adv;
  logic [31:0]       next_job_id_next;
  logic              chk_cand;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_JOBS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign sched_we = accept && (opcode == OP_SCHEDULE) && free_found;
  assign dl_we    = (state == ST_END) && (op_r == OP_TICK) && best_vld && (best_per != '0);
  assign dl_adv   = best_dl + {32'd0, best_per};

  // Zero marks a failed schedule, so the counter skips it on wrap.
  assign next_job_id_next = (next_job_id == 32'hFFFF_FFFF) ? 32'd1 : next_job_id + 32'd1;

  // Due, not yet fired this tick, and strictly earlier than the best so far;
  // the ascending scan makes ties go to the lower slot.
  assign chk_cand = slot_valid[chk_idx] && !fired[chk_idx] && (dl_q <= now_ms) &&
                    (!best_vld || (dl_q < best_dl));

  always_ff @(posedge clk) begin
    if (sched_we) begin
      id_mem[free_idx]  <= next_job_id;
      dl_mem[free_idx]  <= now_ms + {32'd0, delay_ms};
      per_mem[free_idx] <= period_ms;
    end
    if (dl_we) begin
      dl_mem[best_idx] <= dl_adv;
    end
    id_q  <= id_mem[scan_idx];
    dl_q  <= dl_mem[scan_idx];
    per_q <= per_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      now_ms      <= '0;
      next_job_id <= 32'd1;
      slot_valid  <= '0;
      fired       <= '0;
      strobe      <= 1'b0;
      chk_vld     <= 1'b0;
      scan_idx    <= '0;
      found       <= 1'b0;
      best_vld    <= 1'b0;
      pend_vld    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_r     <= opcode;
            op_id    <= job_id;
            scan_idx <= '0;
            chk_vld  <= 1'b0;
            found    <= 1'b0;
            best_vld <= 1'b0;
            pend_vld <= 1'b0;
            fired    <= '0;
            if (opcode == OP_SCHEDULE) begin
              strobe <= 1'b1;
              kind   <= KIND_SCHEDULE;
              last   <= 1'b1;
              if (free_found) begin
                slot_valid[free_idx] <= 1'b1;
                result_id            <= next_job_id;
                ok                   <= 1'b1;
                next_job_id          <= next_job_id_next;
              end else begin
                result_id <= '0;
                ok        <= 1'b0;
              end
            end else begin
              if (opcode == OP_TICK) begin
                now_ms <= now_ms + 64'd1;
              end
              state <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          scan_idx <= scan_idx + SLOT_W'(1);
          chk_idx  <= scan_idx;
          chk_vld  <= 1'b1;
          if (chk_vld) begin
            if (op_r == OP_TICK) begin
              if (chk_cand) begin
                best_vld <= 1'b1;
                best_idx <= chk_idx;
                best_dl  <= dl_q;
                best_per <= per_q;
                best_id  <= id_q;
              end
            end else if (!found && slot_valid[chk_idx] && (id_q == op_id)) begin
              found     <= 1'b1;
              match_idx <= chk_idx;
            end
            if (chk_idx == SLOT_W'(MAX_JOBS - 1)) begin
              state <= ST_END;
            end
          end
        end

        ST_END: begin
          if (op_r == OP_TICK) begin
            // A fire word is held back one pass so that last can be set on it.
            if (pend_vld) begin
              strobe    <= 1'b1;
              kind      <= KIND_FIRED;
              result_id <= pend_id;
              ok        <= 1'b1;
              last      <= !best_vld;
            end
            if (best_vld) begin
              fired[best_idx] <= 1'b1;
              if (best_per == '0) begin
                slot_valid[best_idx] <= 1'b0;
              end
              pend_vld <= 1'b1;
              pend_id  <= best_id;
              best_vld <= 1'b0;
              scan_idx <= '0;
              chk_vld  <= 1'b0;
              state    <= ST_SCAN;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            if ((op_r == OP_CANCEL) && found) begin
              slot_valid[match_idx] <= 1'b0;
            end
            strobe    <= 1'b1;
            kind      <= (op_r == OP_CANCEL) ? KIND_CANCEL : KIND_QUERY;
            result_id <= op_id;
            ok        <= found;
            last      <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/timer_table_checker.sv @@
`timescale 1ns / 1ps
module timer_table_checker
  import potmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] delay_ms,
  input  logic [31:0] period_ms,
  input  logic [31:0] job_id,
  input  logic        strobe,
  input  logic [1:0]  kind,
  input  logic [31:0] result_id,
  input  logic        ok,
  input  logic        last,
  output int          errors,
  output int          pending
);

  localparam int FIRES_PER_TICK = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] id;
    logic        ok;
    logic        last;
  } timer_word_t;

  timer_word_t reply_words[$];

  logic [63:0] clock_ms;
  logic [31:0] id_counter;
  logic        slot_live  [MAX_JOBS];
  logic [31:0] slot_job   [MAX_JOBS];
  logic [63:0] slot_due   [MAX_JOBS];
  logic [31:0] slot_every [MAX_JOBS];
  int          mismatches = 0;

  function automatic void push_word(logic [1:0] k, logic [31:0] id, logic o, logic l);
    timer_word_t w;
    w.kind = k;
    w.id   = id;
    w.ok   = o;
    w.last = l;
    reply_words.push_back(w);
  endfunction

  // Lowest live slot holding the id, or -1.
  function automatic int find_job(logic [31:0] id);
    int hit;
    hit = -1;
    for (int i = MAX_JOBS - 1; i >= 0; i--)
      if (slot_live[i] && slot_job[i] == id) hit = i;
    return hit;
  endfunction

  task automatic run_timer_command(logic [1:0] op, logic [31:0] d, logic [31:0] p,
                                   logic [31:0] id);
    int          free_slot;
    int          hit;
    int          pick;
    int          n;
    logic        fired     [MAX_JOBS];
    logic [31:0] fired_ids [FIRES_PER_TICK];
    case (op)
      OP_SCHEDULE: begin
        free_slot = -1;
        for (int i = MAX_JOBS - 1; i >= 0; i--)
          if (!slot_live[i]) free_slot = i;
        if (free_slot < 0) begin
          push_word(KIND_SCHEDULE, 32'd0, 1'b0, 1'b1);
        end else begin
          slot_live[free_slot]  = 1'b1;
          slot_job[free_slot]   = id_counter;
          slot_due[free_slot]   = clock_ms + {32'd0, d};
          slot_every[free_slot] = p;
          push_word(KIND_SCHEDULE, id_counter, 1'b1, 1'b1);
          id_counter = id_counter + 32'd1;
          if (id_counter == 32'd0) id_counter = 32'd1;
        end
      end
      OP_CANCEL: begin
        hit = find_job(id);
        if (hit >= 0) slot_live[hit] = 1'b0;
        push_word(KIND_CANCEL, id, hit >= 0, 1'b1);
      end
      OP_QUERY: begin
        hit = find_job(id);
        push_word(KIND_QUERY, id, hit >= 0, 1'b1);
      end
      OP_TICK: begin
        clock_ms = clock_ms + 64'd1;
        for (int i = 0; i < MAX_JOBS; i++) fired[i] = 1'b0;
        n = 0;
        pick = 0;
        // Earliest due job first; a strict compare keeps ties on the lower slot.
        while (n < FIRES_PER_TICK && pick >= 0) begin
          pick = -1;
          for (int i = 0; i < MAX_JOBS; i++) begin
            if (slot_live[i] && !fired[i] && slot_due[i] <= clock_ms) begin
              if (pick < 0) pick = i;
              else if (slot_due[i] < slot_due[pick]) pick = i;
            end
          end
          if (pick >= 0) begin
            fired[pick] = 1'b1;
            fired_ids[n] = slot_job[pick];
            n++;
            if (slot_every[pick] != 32'd0)
              slot_due[pick] = slot_due[pick] + {32'd0, slot_every[pick]};
            else
              slot_live[pick] = 1'b0;
          end
        end
        for (int k = 0; k < n; k++) push_word(KIND_FIRED, fired_ids[k], 1'b1, k == n - 1);
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    timer_word_t want;
    if (rst) begin
      clock_ms   = 64'd0;
      id_counter = 32'd1;
      for (int i = 0; i < MAX_JOBS; i++) slot_live[i] = 1'b0;
      reply_words.delete();
    end else begin
      if (strobe) begin
        if (reply_words.size() == 0) begin
          $error("word with no reply pending: kind %0d result_id %0d ok %0d last %0d",
                 kind, result_id, ok, last);
          mismatches++;
        end else begin
          want = reply_words.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            mismatches++;
          end
          if (result_id !== want.id) begin
            $error("result_id: expected %0d, actual %0d", want.id, result_id);
            mismatches++;
          end
          if (ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, ok);
            mismatches++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            mismatches++;
          end
        end
      end
      if (start && !busy) run_timer_command(opcode, delay_ms, period_ms, job_id);
    end
    errors  <= mismatches;
    pending <= reply_words.size();
  end

endmodule

@@ tb/sv/tb_periodic_oneshot_timer_table.sv @@
`timescale 1ns / 1ps
module tb_periodic_oneshot_timer_table;
  import potmr_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int RANDOM_WORDS = 220;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic [1:0]  opcode    = OP_SCHEDULE;
  logic [31:0] delay_ms  = '0;
  logic [31:0] period_ms = '0;
  logic [31:0] job_id    = '0;
  logic        busy;
  logic        strobe;
  logic [1:0]  kind;
  logic [31:0] result_id;
  logic        ok;
  logic        last;
  int          errors;
  int          pending;
  int          quiet_cycles = 0;
  int          sched_count  = 0;
  bit          no_gaps      = 1'b0;

  always #5 clk = ~clk;

  periodic_oneshot_timer_table DUT (.*);

  timer_table_checker monitor (.*);

  // Watchdog: too long without any word moving on either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves start high on return so a back-to-back word needs no lowering.
  task automatic issue_word(logic [1:0] op, logic [31:0] d, logic [31:0] p, logic [31:0] id);
    start     <= 1'b1;
    opcode    <= op;
    delay_ms  <= d;
    period_ms <= p;
    job_id    <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_SCHEDULE) sched_count++;
  endtask

  task automatic sender_gap();
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 18);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic random_word();
    logic [1:0]  op;
    logic [31:0] d;
    logic [31:0] p;
    logic [31:0] id;
    int          roll;
    int          lo;
    roll = $urandom_range(0, 99);
    op = roll < 30 ? OP_SCHEDULE : roll < 48 ? OP_CANCEL : roll < 62 ? OP_QUERY : OP_TICK;
    d  = $urandom;
    p  = $urandom;
    id = $urandom;
    if (op == OP_SCHEDULE) begin
      // Mostly short delays and periods so jobs actually come due.
      if ($urandom_range(0, 9) != 0) d = $urandom_range(0, 8);
      roll = $urandom_range(0, 19);
      if (roll < 10) p = 32'd0;
      else if (roll < 18) p = $urandom_range(1, 6);
    end else if ($urandom_range(0, 9) < 8) begin
      lo = sched_count > 24 ? sched_count - 24 : 1;
      id = $urandom_range(lo, sched_count + 1);
    end
    issue_word(op, d, p, id);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue_word(OP_QUERY, 32'd0, 32'd0, 32'd0);            sender_gap();
    issue_word(OP_CANCEL, 32'd0, 32'd0, 32'd1);           sender_gap();
    issue_word(OP_TICK, 32'd0, 32'd0, 32'd0);             sender_gap();
    issue_word(OP_SCHEDULE, 32'd0, 32'd0, 32'd0);         sender_gap();
    issue_word(OP_SCHEDULE, 32'd0, 32'd1, 32'd0);         sender_gap();
    issue_word(OP_SCHEDULE, 32'd2, 32'd0, 32'd0);         sender_gap();
    issue_word(OP_SCHEDULE, 32'd1, 32'd3, 32'd0);         sender_gap();
    issue_word(OP_SCHEDULE, 32'd0, 32'd0, 32'd0);         sender_gap();
    // Three jobs share a deadline here, so the slot order decides.
    issue_word(OP_TICK, 32'd0, 32'd0, 32'd0);             sender_gap();
    issue_word(OP_TICK, 32'd0, 32'd0, 32'd0);             sender_gap();
    issue_word(OP_QUERY, 32'd0, 32'd0, 32'd2);            sender_gap();
    issue_word(OP_CANCEL, 32'd0, 32'd0, 32'd2);           sender_gap();
    issue_word(OP_CANCEL, 32'd0, 32'd0, 32'd2);           sender_gap();
    issue_word(OP_QUERY, 32'd0, 32'd0, 32'd1);            sender_gap();
    issue_word(OP_QUERY, 32'd0, 32'd0, 32'd4);            sender_gap();
    issue_word(OP_SCHEDULE, '1, '1, 32'd0);               sender_gap();
    issue_word(OP_SCHEDULE, 32'd0, '1, '1);               sender_gap();
    issue_word(OP_TICK, '1, '1, '1);                      sender_gap();
    issue_word(OP_CANCEL, '1, '1, '1);                    sender_gap();
    issue_word(OP_QUERY, 32'd0, 32'd0, '1);
    drain_replies();

    // Overfill the table with near jobs, then let many fire in one tick.
    for (int k = 0; k < 18; k++) begin
      issue_word(OP_SCHEDULE, $urandom_range(0, 3), $urandom_range(0, 2), $urandom);
      sender_gap();
    end
    for (int k = 0; k < 4; k++) begin
      issue_word(OP_TICK, $urandom, $urandom, $urandom);
      sender_gap();
    end

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
      random_word();
      sender_gap();
      if (k == RANDOM_WORDS / 2) drain_replies();
    end

    drain_replies();
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
